// ----- rtl/core/rlmd_pkg.sv -----
`timescale 1ns / 1ps

package rlmd_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] MODE_PIXEL = 2'd0;
   localparam logic [1:0] MODE_CORR  = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   // correction load
   localparam int          CORR_WORDS = 24;
   localparam int          CORR_CW    = 5;
   localparam logic [3:0]  CORR_BITS  = 4'd6;
   localparam logic [3:0]  GRAY_BITS  = 4'd8;
   localparam logic [5:0]  DOT_RESET  = 6'd63;

   // bank line levels
   localparam logic BANK_CORR = 1'b0;
   localparam logic BANK_GRAY = 1'b1;

   // color channel order on the wire: blue, green, red
   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_RED   = 2'd2;

   // pixel gathering phase
   localparam logic [1:0] PHASE_RED   = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CORR,
      SEQ_GRAY
   } seq_state_type;

   // run request from the front end to the word sequencer
   typedef struct packed {
      logic corr;
      logic gray;
   } run_req_type;

endpackage

// ----- rtl/core/rgb_led_matrix_row_driver_top.sv -----
`timescale 1ns / 1ps

// RGB LED matrix row driver. Image bytes stream in red, green, blue order
// (req_tuser = 0); every third byte completes a pixel that is written into
// the row buffer, and the pixel for the last column triggers a grayscale
// run: 3*COLUMNS eight-bit bank 1 words (columns high to low, each blue,
// green, red), all rows off until the final word, which is latched and
// turns the current row on before the row counter advances. req_tuser = 1
// loads 24 six-bit bank 0 words of the dot-correction register, and
// req_tuser = 2 sends the buffer as it stands to the current row. Each rsp
// transfer is one shifted word. A byte that does not finish a row leaves
// req_tready high; a run holds req_tready low until its last word is
// loaded into the output register (24 words for a correction load,
// 3*COLUMNS for a grayscale run), the word sequencer loading one word per
// cycle while rsp_tready does not stall. The row buffer clears at reset.

module rgb_led_matrix_row_driver_top
   import rlmd_pkg::*;
#(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel_byte
   input  logic [1:0]  req_tuser,    // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] word_value, [11:8] word_bits,
                                     // [12] latch_after, [16:13] row_enable
   output logic        rsp_tuser,    // [0] bank_select
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data      // dot_correction
);

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   logic          req_xfer;
   logic          byte_strobe;
   logic          row_done;
   logic          seq_idle;
   logic [CW-1:0] rd_col;
   logic [23:0]   rd_pixel;
   logic [5:0]    dot_ff;
   run_req_type   start;

   // dot-correction register, writable any time the block is idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= DOT_RESET;
      end else if (csr_valid && csr_ready) begin
         dot_ff <= csr_data;
      end
   end

   // requests are taken only while the sequencer has no run in progress
   assign req_tready  = seq_idle;
   assign req_xfer    = req_tvalid && req_tready;
   assign byte_strobe = req_xfer && (req_tuser == MODE_PIXEL);

   // a completed row and a flush both start a grayscale run;
   // the unused mode is accepted and dropped
   assign start.corr = req_xfer && (req_tuser == MODE_CORR);
   assign start.gray = row_done || (req_xfer && (req_tuser == MODE_FLUSH));

   rlmd_pixel_buf #(
      .COLUMNS (COLUMNS),
      .CW      (CW)
   ) u_pixel_buf (
      .clock       (clock),
      .reset       (reset),
      .byte_strobe (byte_strobe),
      .pixel_byte  (req_tdata),
      .rd_col      (rd_col),
      .rd_pixel    (rd_pixel),
      .row_done    (row_done)
   );

   rlmd_word_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CW      (CW),
      .RW      (RW)
   ) u_word_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .dot_corr   (dot_ff),
      .rd_pixel   (rd_pixel),
      .rd_col     (rd_col),
      .idle       (seq_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/rlmd_pixel_buf.sv -----
`timescale 1ns / 1ps

module rlmd_pixel_buf
   import rlmd_pkg::*;
#(
   parameter int COLUMNS = 8,
   parameter int CW      = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_strobe,
   input  logic [7:0]    pixel_byte,
   input  logic [CW-1:0] rd_col,
   output logic [23:0]   rd_pixel,
   output logic          row_done
);

   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    red_ff, red_in;
   logic [7:0]    green_ff, green_in;
   logic [CW-1:0] col_ff, col_in;
   logic [23:0]   buf_ff [COLUMNS];
   logic          wr_en;
   logic [CW-1:0] wr_col;

   always_comb begin
      phase_in = phase_ff;
      red_in   = red_ff;
      green_in = green_ff;
      col_in   = col_ff;
      wr_en    = 1'b0;
      row_done = 1'b0;
      // out-of-range column folds back to zero
      wr_col   = (32'(col_ff) >= COLUMNS) ? '0 : col_ff;
      if (byte_strobe) begin
         unique case (phase_ff)
            PHASE_GREEN: begin
               green_in = pixel_byte;
               phase_in = PHASE_BLUE;
            end
            PHASE_BLUE: begin
               phase_in = PHASE_RED;
               wr_en    = 1'b1;
               if (32'(wr_col) == COLUMNS - 1) begin
                  col_in   = '0;
                  row_done = 1'b1;
               end else begin
                  col_in = wr_col + CW'(1);
               end
            end
            default: begin
               // red, and the unused phase code
               red_in   = pixel_byte;
               phase_in = PHASE_GREEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_RED;
         red_ff   <= '0;
         green_ff <= '0;
         col_ff   <= '0;
         for (int i = 0; i < COLUMNS; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         col_ff   <= col_in;
         if (wr_en) begin
            buf_ff[wr_col] <= {red_ff, green_ff, pixel_byte};
         end
      end
   end

   assign rd_pixel = buf_ff[rd_col];

endmodule

// ----- rtl/core/rlmd_word_seq.sv -----
`timescale 1ns / 1ps

module rlmd_word_seq
   import rlmd_pkg::*;
#(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 8,
   parameter int CW      = 3,
   parameter int RW      = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  run_req_type   start,
   input  logic [5:0]    dot_corr,
   input  logic [23:0]   rd_pixel,
   output logic [CW-1:0] rd_col,
   output logic          idle,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   localparam logic [3:0] ROWS_OFF = 4'(ROWS);

   seq_state_type    state_ff, state_in;
   logic [CORR_CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [1:0]       chan_ff, chan_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [3:0]       lines_ff, lines_in;

   logic             vld_ff, vld_in;
   logic             bank_ff, bank_in;
   logic [7:0]       value_ff, value_in;
   logic [3:0]       bits_ff, bits_in;
   logic             last_ff, last_in;
   logic [3:0]       rowen_ff, rowen_in;

   logic             out_free;
   logic             gray_last;
   logic [7:0]       chan_byte;

   assign out_free  = !vld_ff || rsp_tready;
   assign gray_last = (col_ff == '0) && (chan_ff == CHAN_RED);
   // shared byte selector over the pixel word
   assign chan_byte = 8'(rd_pixel >> {chan_ff, 3'b000});
   assign rd_col    = col_ff;
   assign idle      = (state_ff == SEQ_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      col_in   = col_ff;
      chan_in  = chan_ff;
      row_in   = row_ff;
      lines_in = lines_ff;
      vld_in   = vld_ff && !rsp_tready;
      bank_in  = bank_ff;
      value_in = value_ff;
      bits_in  = bits_ff;
      last_in  = last_ff;
      rowen_in = rowen_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start.corr) begin
               state_in = SEQ_CORR;
               cnt_in   = '0;
            end else if (start.gray) begin
               state_in = SEQ_GRAY;
               col_in   = CW'(COLUMNS - 1);
               chan_in  = CHAN_BLUE;
            end
         end
         SEQ_CORR: begin
            if (out_free) begin
               vld_in   = 1'b1;
               bank_in  = BANK_CORR;
               value_in = {2'b00, dot_corr};
               bits_in  = CORR_BITS;
               last_in  = (cnt_ff == CORR_CW'(CORR_WORDS - 1));
               rowen_in = lines_ff;
               cnt_in   = cnt_ff + CORR_CW'(1);
               if (last_in) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         SEQ_GRAY: begin
            if (out_free) begin
               vld_in   = 1'b1;
               bank_in  = BANK_GRAY;
               value_in = chan_byte;
               bits_in  = GRAY_BITS;
               last_in  = gray_last;
               rowen_in = gray_last ? 4'(row_ff) : ROWS_OFF;
               if (chan_ff == CHAN_RED) begin
                  chan_in = CHAN_BLUE;
                  col_in  = col_ff - CW'(1);
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
               if (gray_last) begin
                  lines_in = 4'(row_ff);
                  row_in   = (32'(row_ff) == ROWS - 1) ? '0 : row_ff + RW'(1);
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         row_ff   <= '0;
         lines_ff <= ROWS_OFF;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         lines_ff <= lines_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      col_ff   <= col_in;
      chan_ff  <= chan_in;
      bank_ff  <= bank_in;
      value_ff <= value_in;
      bits_ff  <= bits_in;
      last_ff  <= last_in;
      rowen_ff <= rowen_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = bank_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, rowen_ff, last_ff, bits_ff, value_ff};

   // a run only starts from idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start.corr || start.gray) |-> (state_ff == SEQ_IDLE))
      else $error("run started while sequencer busy");

   // grayscale words before the final one keep all rows off
   a_rows_off: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && bank_ff == BANK_GRAY && !last_ff) |-> (rowen_ff == ROWS_OFF))
      else $error("row line on during grayscale shift");

   // correction words are six bits wide
   a_corr_bits: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && bank_ff == BANK_CORR) |-> (bits_ff == CORR_BITS))
      else $error("bad bit count on correction word");

   // the final grayscale word ends the run
   a_gray_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_GRAY && out_free && gray_last) |=> (state_ff == SEQ_IDLE))
      else $error("sequencer did not return to idle after final word");

   // the row counter moves only when a grayscale run ends; checked over correction loads
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_CORR) |=> $stable(row_ff))
      else $error("row counter moved during correction load");

endmodule

// ----- verif/rgb_led_matrix_row_driver_top_test.sv -----
`timescale 1ns / 1ps

module rgb_led_matrix_row_driver_top_test;
   import rlmd_pkg::*;

   localparam int COLUMNS    = 8;
   localparam int ROWS       = 8;
   // longest correct quiet stretch is the LONG_HOLD output hold, so this is several times over
   localparam int IDLE_LIMIT = 3000;
   // settle time once nothing is expected, so this covers any tail of work
   localparam int SETTLE     = 40;
   localparam int LONG_HOLD  = 400;

   // one shifted word as it leaves the block
   typedef struct {
      logic       bank;
      logic [7:0] value;
      logic [3:0] bits;
      logic       latch;
      logic [3:0] row;
      logic       last;
   } shifted_word_type;

   // one request as offered on the input stream
   typedef struct {
      logic [1:0] mode;
      logic [7:0] pixel;
   } request_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = MODE_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data   = '0;

   // model of the block: pixel gathering, row buffer, row counter, driven row line
   logic [5:0]  dot_level   = DOT_RESET;
   logic [1:0]  pixel_phase = PHASE_RED;
   logic [7:0]  red_byte    = '0;
   logic [7:0]  green_byte  = '0;
   int          next_column = 0;
   logic [3:0]  row_now     = '0;
   logic [3:0]  lit_row     = 4'(ROWS);
   logic [23:0] row_pixels [COLUMNS] = '{default: '0};

   shifted_word_type expected_words[$];
   request_type      queued_requests[$];
   request_type      next_req;

   // stimulus shaping
   int burst_left    = 1;
   int gap_left      = 0;
   int hold_left     = 0;
   int stall_clock   = 0;
   bit do_pressure   = 1'b0;
   bit pressure_done = 1'b0;
   bit req_took      = 1'b0;

   // bookkeeping
   int idle_cycles    = 0;
   int mismatch_count = 0;
   int requests_taken = 0;
   int words_checked  = 0;
   int gray_runs      = 0;
   int corr_runs      = 0;
   int config_writes  = 0;

   rgb_led_matrix_row_driver_top #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // grayscale run: columns high to low, each blue, green, red; rows off until the
   // final word, which latches and lights the current row
   task automatic queue_gray_run();
      shifted_word_type w;
      logic [23:0]      px;
      int               k;
      k = 0;
      for (int c = COLUMNS - 1; c >= 0; c--) begin
         px = row_pixels[c];
         for (int ch = 0; ch < 3; ch++) begin
            w.bank  = BANK_GRAY;
            w.value = px[8 * ch +: 8];
            w.bits  = GRAY_BITS;
            w.last  = (k == 3 * COLUMNS - 1);
            w.latch = w.last;
            w.row   = w.last ? row_now : 4'(ROWS);
            expected_words.push_back(w);
            k++;
         end
      end
      lit_row = row_now;
      row_now = (row_now + 1 >= ROWS) ? 4'd0 : row_now + 4'd1;
      gray_runs++;
   endtask

   // work out the words one accepted request causes
   task automatic predict_words(logic [1:0] mode, logic [7:0] pixel);
      shifted_word_type w;
      case (mode)
         MODE_CORR: begin
            // row line left alone during a correction load
            for (int k = 0; k < CORR_WORDS; k++) begin
               w.bank  = BANK_CORR;
               w.value = {2'b00, dot_level};
               w.bits  = CORR_BITS;
               w.last  = (k == CORR_WORDS - 1);
               w.latch = w.last;
               w.row   = lit_row;
               expected_words.push_back(w);
            end
            corr_runs++;
         end
         MODE_FLUSH: queue_gray_run();   // a half-gathered pixel stays pending
         MODE_PIXEL: begin
            case (pixel_phase)
               PHASE_GREEN: begin
                  green_byte  = pixel;
                  pixel_phase = PHASE_BLUE;
               end
               PHASE_BLUE: begin
                  pixel_phase = PHASE_RED;
                  if (next_column >= COLUMNS) next_column = 0;
                  row_pixels[next_column] = {red_byte, green_byte, pixel};
                  // pixel is stored first, then the full row goes out
                  if (next_column + 1 >= COLUMNS) begin
                     next_column = 0;
                     queue_gray_run();
                  end else begin
                     next_column = next_column + 1;
                  end
               end
               default: begin
                  red_byte    = pixel;
                  pixel_phase = PHASE_GREEN;
               end
            endcase
         end
         default: ;                      // unused mode, nothing comes out
      endcase
   endtask

   task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_word();
      shifted_word_type want;
      if (expected_words.size() == 0) begin
         $error("word_value expected none actual %0d", rsp_tdata[7:0]);
         mismatch_count++;
      end else begin
         want = expected_words.pop_front();
         words_checked++;
         compare_field("bank_select", 8'(want.bank),  8'(rsp_tuser));
         compare_field("word_value",  want.value,     rsp_tdata[7:0]);
         compare_field("word_bits",   8'(want.bits),  8'(rsp_tdata[11:8]));
         compare_field("latch_after", 8'(want.latch), 8'(rsp_tdata[12]));
         compare_field("row_enable",  8'(want.row),   8'(rsp_tdata[16:13]));
         compare_field("last",        8'(want.last),  8'(rsp_tlast));
      end
   endtask

   // monitor: sample transfers at the rising edge, feed the model, check words
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) dot_level = csr_data;
         if (req_tvalid && req_tready) begin
            predict_words(req_tuser, req_tdata);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_word();
      end
   end

   // driver: bursts of requests with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (gap_left > 0 || queued_requests.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            next_req = queued_requests.pop_front();
            req_tuser  <= next_req.mode;
            req_tdata  <= next_req.pixel;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               // about a quarter of bursts follow straight on
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // receiver: rotating stall pattern, plus one long hold when asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_clock++;
         if (do_pressure && !pressure_done) begin
            hold_left     = LONG_HOLD;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((stall_clock / 64) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (stall_clock % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic add_request(logic [1:0] mode, logic [7:0] pixel);
      request_type r;
      r.mode  = mode;
      r.pixel = pixel;
      queued_requests.push_back(r);
   endtask

   // mostly runs of whole pixels with random content, the rest flushes,
   // correction loads, unused modes and broken pixels
   task automatic add_random_requests(int count);
      int         added;
      int         pick;
      int         len;
      logic [7:0] b;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = 3 * $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0: b = 8'h00;
                  1: b = 8'hFF;
                  default: b = 8'($urandom);
               endcase
               add_request(MODE_PIXEL, b);
            end
            added += len;
         end else if (pick < 80) begin
            add_request(MODE_FLUSH, 8'($urandom));
            added++;
         end else if (pick < 88) begin
            add_request(MODE_CORR, 8'($urandom));
            added++;
         end else if (pick < 94) begin
            add_request(MODE_NONE, 8'($urandom));
            added++;
         end else begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++) add_request(MODE_PIXEL, 8'($urandom));
            added += len;
         end
      end
   endtask

   // block is idle once nothing is queued, offered or expected, plus a settle time
   task automatic wait_idle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || expected_words.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_dot_level(logic [5:0] level);
      @(negedge clock);
      csr_data  <= level;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      config_writes++;
   endtask

   logic [7:0] row_bytes [24] = '{
      8'hFF, 8'h00, 8'h80,  8'h01, 8'hFE, 8'h7F,  8'hAA, 8'h55, 8'h0F,
      8'hF0, 8'h33, 8'hCC,  8'hFF, 8'hFF, 8'hFF,  8'h00, 8'h00, 8'h00,
      8'h12, 8'h34, 8'h56,  8'h9A, 8'hBC, 8'hDE
   };

   initial begin
      logic [5:0] level;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: load at reset value with all rows off, flush of the cleared
      // buffer, an unused mode, one full row of edge values, then an
      // incomplete pixel left pending across a flush
      add_request(MODE_CORR,  8'h00);
      add_request(MODE_FLUSH, 8'hFF);
      add_request(MODE_NONE,  8'hFF);
      foreach (row_bytes[i]) add_request(MODE_PIXEL, row_bytes[i]);
      add_request(MODE_PIXEL, 8'h5A);
      add_request(MODE_PIXEL, 8'hA5);
      add_request(MODE_FLUSH, 8'h00);
      wait_idle();

      // random phases, each under its own correction level, extremes first
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: level = 6'd0;
            1: level = 6'd63;
            default: level = 6'($urandom_range(0, 63));
         endcase
         write_dot_level(level);
         add_request(MODE_CORR, 8'($urandom));
         add_random_requests(60);
         // first phase: hold the output long enough to back up the input
         if (ph == 0) do_pressure = 1'b1;
         wait_idle();
      end

      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         mismatch_count++;
      end
      $display("%0d requests, %0d grayscale runs, %0d correction loads, %0d words checked",
               requests_taken, gray_runs, corr_runs, words_checked);
      $display("%0d correction level writes, one long output hold under input pressure",
               config_writes);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
